@@ design/bissc_pkg.sv @@
// Shared constants, types and CRC table for the BiSS-C frame decoder.
// No dependencies; compiled first.
package bissc_pkg;

  localparam int unsigned FRAME_BITS_DEF = 64;  // default received frame length
  localparam int unsigned RAW_W          = 64;  // raw frame port width
  localparam int unsigned POS_W          = 28;  // position field width
  localparam int unsigned PB_W           = 5;   // position_bits register width
  localparam int unsigned CRC_W          = 6;
  localparam int unsigned CNT_W          = 32;

  localparam int unsigned PB_MIN   = 8;
  localparam int unsigned PB_MAX   = 28;
  localparam int unsigned PB_RESET = 22;
  localparam int unsigned HDR_BITS = 10;        // crc + warn + err + 2 spare above pb

  // window that holds the kept bits: pb + 10 at most
  localparam int unsigned WIN_W  = PB_MAX + HDR_BITS;
  // CRC covers position, error and warning
  localparam int unsigned DATA_W = PB_MAX + 2;

  // x^(i+6) mod (x^6 + x + 1): CRC contribution of data bit i, zero seed
  localparam logic [CRC_W-1:0] CRC_TERM [DATA_W] = '{
    6'h03, 6'h06, 6'h0C, 6'h18, 6'h30, 6'h23, 6'h05, 6'h0A, 6'h14, 6'h28,
    6'h13, 6'h26, 6'h0F, 6'h1E, 6'h3C, 6'h3B, 6'h35, 6'h29, 6'h11, 6'h22,
    6'h07, 6'h0E, 6'h1C, 6'h38, 6'h33, 6'h25, 6'h09, 6'h12, 6'h24, 6'h0B
  };

  // fields pulled out of one aligned frame
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              err;
    logic              warn;
    logic [CRC_W-1:0]  crc_rx;
    logic [DATA_W-1:0] data;
    logic              nonzero;
  } fields_t;

endpackage

@@ design/bissc_in_if.sv @@
// Input channel: one raw receive frame per word, valid/ready handshake.
// Depends on bissc_pkg.
interface bissc_in_if;
  import bissc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_frame;

  modport source (output valid, output raw_frame, input ready);
  modport sink   (input valid, input raw_frame, output ready);
endinterface

@@ design/bissc_out_if.sv @@
// Output channel: one decoded result per word, valid/ready handshake.
// Depends on bissc_pkg.
interface bissc_out_if;
  import bissc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] raw_position;
  logic [POS_W-1:0] good_position;
  logic             crc_ok;
  logic             error_bit;
  logic             warning_bit;
  logic [CNT_W-1:0] crc_error_count;

  modport source (output valid, output raw_position, output good_position, output crc_ok,
                  output error_bit, output warning_bit, output crc_error_count,
                  input ready);
  modport sink   (input valid, input raw_position, input good_position, input crc_ok,
                  input error_bit, input warning_bit, input crc_error_count,
                  output ready);
endinterface

@@ design/bissc_align.sv @@
// Frame alignment and field extraction: strips start/CDS bits, trims to pb+10 bits.
// Depends on bissc_pkg.
module bissc_align #(
  parameter int unsigned FRAME_BITS = bissc_pkg::FRAME_BITS_DEF
) (
  input  logic [FRAME_BITS-1:0]      frame_i,
  input  logic [bissc_pkg::PB_W-1:0] pb_i,      // already clamped to 8..28
  output bissc_pkg::fields_t         fields_o
);
  import bissc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(FRAME_BITS);
  localparam int unsigned CALC_W = $clog2(2 * FRAME_BITS + WIN_W);

  function automatic logic [IDX_W-1:0] top_idx(input logic [FRAME_BITS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  logic [IDX_W-1:0]            msb;
  logic [IDX_W-1:0]            top;
  logic [FRAME_BITS-1:0]       below;
  logic [FRAME_BITS-1:0]       body;
  logic [CALC_W-1:0]           keep;
  logic [CALC_W-1:0]           rsh;
  logic [FRAME_BITS+WIN_W-1:0] wide;
  logic [WIN_W-1:0]            win;
  logic [POS_W-1:0]            pos_mask;
  logic [DATA_W-1:0]           data_mask;

  always_comb begin
    msb   = top_idx(frame_i);
    // bits below the start bit and the CDS bit
    below = ((FRAME_BITS'(1) << msb) - FRAME_BITS'(1)) >> 1;
    body  = frame_i & below;
    top   = top_idx(body);
    keep  = CALC_W'(pb_i) + CALC_W'(HDR_BITS);

    // net shift into the window: top bit lands at keep-1, or frame stays left-aligned
    if (keep + CALC_W'(msb) <= CALC_W'(FRAME_BITS) + CALC_W'(top)) begin
      rsh = CALC_W'(WIN_W + 1) + CALC_W'(top) - keep;
    end else begin
      rsh = CALC_W'(WIN_W + 1) + CALC_W'(msb) - CALC_W'(FRAME_BITS);
    end
    wide = {body, WIN_W'(0)} >> rsh;
    win  = wide[WIN_W-1:0];

    pos_mask  = (POS_W'(1) << pb_i) - POS_W'(1);
    data_mask = (DATA_W'(1) << ({1'b0, pb_i} + 6'd2)) - DATA_W'(1);

    fields_o.pos     = win[8 +: POS_W] & pos_mask;
    fields_o.err     = win[7];
    fields_o.warn    = win[6];
    fields_o.crc_rx  = win[CRC_W-1:0];
    fields_o.data    = win[CRC_W +: DATA_W] & data_mask;
    fields_o.nonzero = |frame_i;
  end

endmodule

@@ design/bissc_crc6.sv @@
// Parallel inverted CRC-6 (x^6+x+1, zero seed) compare against the received CRC.
// Depends on bissc_pkg.
module bissc_crc6 (
  input  bissc_pkg::fields_t fields_i,
  output logic               ok_o
);
  import bissc_pkg::*;

  logic [CRC_W-1:0] crc;

  // zero seed: leading zeros add nothing, so each set bit adds its own term
  always_comb begin
    crc = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (fields_i.data[i]) crc = crc ^ CRC_TERM[i];
    end
    ok_o = fields_i.nonzero && ((~crc) == fields_i.crc_rx);
  end

endmodule

@@ design/biss_c_frame_decoder_core.sv @@
// BiSS-C position frame decoder, top level.
// Depends on bissc_pkg, bissc_in_if, bissc_out_if, bissc_align, bissc_crc6.
//
// Usage:
//  - in_word (sink): one raw frame per word, first received bit in bit
//    FRAME_BITS-1; bits above that are ignored.
//  - out_word (source): one result word per frame: extracted position,
//    last CRC-good position, crc_ok, error/warning bits, failed-frame count.
//  - cfg_we_i/cfg_wdata_i: writes position_bits (clamped to 8..28 on use).
//    Write only while no frame is in flight.
// Pipeline: an accepted frame is held in the input register, decoded out of
//  it and loaded into the result register once that register is free or
//  being drained. One frame per cycle sustained while out_word.ready is
//  high; the whole decode (align, trim, CRC, state update) is one
//  combinational pass between the input register and the result register.
// Stall: when out_word.ready is low the result holds, the input register
//  still takes one more word if it is empty, then in_word.ready drops until space frees.
// Reset: both registers empty, position_bits = 22, held position and
//  failed-frame count zero. The count saturates at all ones.
module biss_c_frame_decoder_core #(
  parameter int unsigned FRAME_BITS = bissc_pkg::FRAME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bissc_in_if.sink                   in_word,
  bissc_out_if.source                out_word,
  input  logic                       cfg_we_i,
  input  logic [bissc_pkg::PB_W-1:0] cfg_wdata_i
);
  import bissc_pkg::*;

  // config register
  logic [PB_W-1:0] pb_q;
  logic [PB_W-1:0] pb_eff;

  // input stage
  logic                  in_vld_q;
  logic [FRAME_BITS-1:0] frame_q;

  // result stage and held state
  logic             out_vld_q;
  logic [POS_W-1:0] raw_pos_q;
  logic             ok_q;
  logic             err_q;
  logic             warn_q;
  logic [POS_W-1:0] held_q;
  logic [CNT_W-1:0] cnt_q;

  fields_t fields;
  logic    crc_ok;
  logic    advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q <= PB_W'(PB_RESET);
    end else if (cfg_we_i) begin
      pb_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (pb_q < PB_W'(PB_MIN)) begin
      pb_eff = PB_W'(PB_MIN);
    end else if (pb_q > PB_W'(PB_MAX)) begin
      pb_eff = PB_W'(PB_MAX);
    end else begin
      pb_eff = pb_q;
    end
  end

  // input register moves on when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || out_word.ready);
  assign in_word.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_word.ready) begin
      in_vld_q <= in_word.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_word.valid && in_word.ready) begin
      frame_q <= in_word.raw_frame[FRAME_BITS-1:0];
    end
  end

  bissc_align #(
    .FRAME_BITS (FRAME_BITS)
  ) u_align (
    .frame_i  (frame_q),
    .pb_i     (pb_eff),
    .fields_o (fields)
  );

  bissc_crc6 u_crc6 (
    .fields_i (fields),
    .ok_o     (crc_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_word.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      raw_pos_q <= fields.pos;
      ok_q      <= crc_ok;
      err_q     <= fields.err;
      warn_q    <= fields.warn;
    end
  end

  // held position / failed-frame count change only as a result word is loaded,
  // so they read straight out as that word's state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else if (advance) begin
      if (crc_ok) begin
        held_q <= fields.pos;
      end else if (cnt_q != '1) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  assign out_word.valid           = out_vld_q;
  assign out_word.raw_position    = raw_pos_q;
  assign out_word.good_position   = held_q;
  assign out_word.crc_ok          = ok_q;
  assign out_word.error_bit       = err_q;
  assign out_word.warning_bit     = warn_q;
  assign out_word.crc_error_count = cnt_q;

endmodule

@@ bench/bissc_tb_pkg.sv @@
`timescale 1ns / 1ps
// Bench helpers for the BiSS-C decoder: result word type, CRC-6 and bit utilities.
// Depends on bissc_pkg; shared by the checker and the bench top.
package bissc_tb_pkg;
  import bissc_pkg::*;

  // low terms of x^6 + x + 1
  localparam logic [CRC_W-1:0] CRC6_POLY = 6'h03;
  localparam int unsigned      FRAME_LEN = FRAME_BITS_DEF;

  typedef struct {
    logic [POS_W-1:0] raw_position;
    logic [POS_W-1:0] good_position;
    logic             crc_ok;
    logic             error_bit;
    logic             warning_bit;
    logic [CNT_W-1:0] crc_error_count;
  } decode_t;

  function automatic logic [63:0] low_mask(int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // index of highest set bit, 0 for an empty word
  function automatic int unsigned top_index(logic [63:0] x);
    for (int i = 63; i >= 0; i--) begin
      if (x[i]) return i;
    end
    return 0;
  endfunction

  // position width actually used by the decoder
  function automatic int unsigned clamp_width(logic [PB_W-1:0] v);
    int unsigned w;
    w = 32'(v);
    if (w < PB_MIN) w = PB_MIN;
    if (w > PB_MAX) w = PB_MAX;
    return w;
  endfunction

  // zero seed, MSB first over the low n bits, inverted
  function automatic logic [CRC_W-1:0] crc6_inv(logic [63:0] data, int unsigned n);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = '0;
    for (int i = int'(n) - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ data[i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) c = c ^ CRC6_POLY;
    end
    return ~c;
  endfunction

endpackage

@@ bench/bissc_frame_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of the decoder, predicts each result word and compares.
// Depends on bissc_pkg, bissc_tb_pkg, bissc_in_if, bissc_out_if.
module bissc_frame_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bissc_in_if                        in_mon,
  bissc_out_if                       out_mon,
  input  logic                       cfg_we_i,
  input  logic [bissc_pkg::PB_W-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import bissc_pkg::*;
  import bissc_tb_pkg::*;

  logic [PB_W-1:0]  width_reg;
  logic [POS_W-1:0] held_pos;
  logic [CNT_W-1:0] bad_frames;
  decode_t          decoded_q[$];
  decode_t          want;
  decode_t          next_word;
  int               mismatches;
  int               pending;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
    $display("[%0t] %s: got 0x%0h, wanted 0x%0h", $time, what, got, wanted);
    mismatches++;
  endtask

  // decodes one frame and applies it to the held position and fail count
  function automatic decode_t decode_frame(logic [RAW_W-1:0] frame, logic [PB_W-1:0] wcfg,
                                           logic [POS_W-1:0] held, logic [CNT_W-1:0] bad);
    int unsigned      pb;
    int unsigned      keep;
    int unsigned      msb;
    int unsigned      nb;
    logic [63:0]      x;
    logic [63:0]      data;
    logic [63:0]      pos;
    logic [CRC_W-1:0] crc_rx;
    logic             ok;
    decode_t          d;
    pb    = clamp_width(wcfg);
    keep  = pb + HDR_BITS;
    frame = frame & low_mask(FRAME_LEN);
    pos   = '0;
    d.error_bit   = 1'b0;
    d.warning_bit = 1'b0;
    ok    = 1'b0;
    if (frame != '0) begin
      msb = top_index(frame);
      // start bit to the top, then drop start and CDS
      x  = (frame << (FRAME_LEN - 1 - msb)) & low_mask(FRAME_LEN - 2);
      nb = (x != '0) ? top_index(x) + 1 : 0;
      if (nb >= keep) x = x >> (nb - keep);
      crc_rx = x[CRC_W-1:0];
      data   = (x >> CRC_W) & low_mask(pb + 2);
      pos    = (data >> 2) & low_mask(pb);
      d.error_bit   = data[1];
      d.warning_bit = data[0];
      ok     = (crc6_inv(data, pb + 2) == crc_rx);
    end
    d.raw_position    = pos[POS_W-1:0];
    d.crc_ok          = ok;
    d.good_position   = ok ? pos[POS_W-1:0] : held;
    d.crc_error_count = (ok || bad == '1) ? bad : bad + 1'b1;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = PB_W'(PB_RESET);
      held_pos   = '0;
      bad_frames = '0;
      decoded_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result word with no frame pending", 64'(out_mon.raw_position),
                          '0);
        end else begin
          want = decoded_q.pop_front();
          if (out_mon.raw_position !== want.raw_position)
            report_mismatch("raw_position", 64'(out_mon.raw_position),
                            64'(want.raw_position));
          if (out_mon.good_position !== want.good_position)
            report_mismatch("good_position", 64'(out_mon.good_position),
                            64'(want.good_position));
          if (out_mon.crc_ok !== want.crc_ok)
            report_mismatch("crc_ok", 64'(out_mon.crc_ok), 64'(want.crc_ok));
          if (out_mon.error_bit !== want.error_bit)
            report_mismatch("error_bit", 64'(out_mon.error_bit), 64'(want.error_bit));
          if (out_mon.warning_bit !== want.warning_bit)
            report_mismatch("warning_bit", 64'(out_mon.warning_bit),
                            64'(want.warning_bit));
          if (out_mon.crc_error_count !== want.crc_error_count)
            report_mismatch("crc_error_count", 64'(out_mon.crc_error_count),
                            64'(want.crc_error_count));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        next_word  = decode_frame(in_mon.raw_frame, width_reg, held_pos, bad_frames);
        held_pos   = next_word.good_position;
        bad_frames = next_word.crc_error_count;
        decoded_q.push_back(next_word);
      end
      if (cfg_we_i) width_reg = cfg_wdata_i;
      pending = decoded_q.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Bench top for biss_c_frame_decoder_core: clock, reset, frame stimulus, verdict.
// Depends on bissc_pkg, bissc_tb_pkg, the channel interfaces and bissc_frame_checker.
module tb_top;
  import bissc_pkg::*;
  import bissc_tb_pkg::*;

  // generous watchdog bound for the whole run
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 175;
  localparam int unsigned HOLD_CYCLES  = 300;

  // position width per random phase: extremes, out-of-range values (clamped), mid values
  localparam logic [PB_W-1:0] WIDTH_PLAN [PHASES] = '{
    5'd8, 5'd28, 5'd0, 5'd31, 5'd15, 5'd8, 5'd28, 5'd20
  };
  // traffic per phase, cycled: none, sender idle, receiver stall, both
  localparam int SRC_IDLE   [4] = '{0, 82, 0, 25};
  localparam int SINK_STALL [4] = '{0, 0, 82, 25};

  logic            clk_i  = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we;
  logic [PB_W-1:0] cfg_wdata;

  int          src_idle_pct;
  int          sink_stall_pct;
  logic        rx_block;        // long receiver hold-off
  int unsigned width_now;       // clamped width the frames are built for
  int unsigned cycle_count = 0;
  int          fail_count;
  int          pending;

  bissc_in_if  in_ch ();
  bissc_out_if out_ch ();

  biss_c_frame_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word     (in_ch),
    .out_word    (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  bissc_frame_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, plus the long hold-off when rx_block is set
  always @(negedge clk_i) begin
    out_ch.ready <= !rx_block && (int'($urandom_range(99)) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Frame building. A full frame is: leading zeros, start bit, CDS bit, two
  // spare bits (upper one set so the trim lands on the body), position, error,
  // warning, CRC, then trailing junk that the trim shifts out.
  // --------------------------------------------------------------------------

  // position, error, warning and CRC: width_now + 8 bits
  function automatic logic [63:0] encode_body(logic [POS_W-1:0] pos, logic err, logic warn);
    logic [63:0] data;
    data = ((64'(pos) & low_mask(width_now)) << 2) | {62'd0, err, warn};
    return (data << CRC_W) | 64'(crc6_inv(data, width_now + 2));
  endfunction

  function automatic logic [RAW_W-1:0] full_frame(logic [POS_W-1:0] pos, logic err,
                                                  logic warn);
    int unsigned keep;
    int unsigned lead;
    int unsigned tail;
    logic [63:0] body;
    logic [63:0] f;
    logic [63:0] junk;
    keep = width_now + HDR_BITS;
    body = encode_body(pos, err, warn) | (64'd1 << (keep - 1))
         | (64'($urandom_range(1)) << (keep - 2));
    lead = $urandom_range(FRAME_LEN - 2 - keep);
    tail = FRAME_LEN - 2 - keep - lead;
    junk = {$urandom, $urandom};
    f    = (64'd1 << (keep + 1)) | (64'($urandom_range(1)) << keep) | body;
    return (f << tail) | (junk & low_mask(tail));
  endfunction

  // Short frame: start bit in the top bit and no spare bits, so fewer bits
  // than the kept length remain and the fields come from the low end untrimmed.
  function automatic logic [RAW_W-1:0] short_frame(logic [POS_W-1:0] pos, logic err,
                                                   logic warn);
    return (64'd1 << (FRAME_LEN - 1)) | (64'($urandom_range(1)) << (FRAME_LEN - 2))
         | encode_body(pos, err, warn);
  endfunction

  function automatic logic [POS_W-1:0] random_pos();
    unique case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // junk that mostly fails the CRC: empty frame, all ones, one or two set
  // bits (nothing left after the drop), random words of random length
  function automatic logic [RAW_W-1:0] noise_frame();
    unique case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      3:       return 64'd3 << $urandom_range(62);
      4:       return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly well-formed frames with random content, the rest broken or junk
  function automatic logic [RAW_W-1:0] random_item();
    int unsigned      r;
    logic [POS_W-1:0] pos;
    logic             err;
    logic             warn;
    r    = $urandom_range(99);
    pos  = random_pos();
    err  = 1'($urandom_range(1));
    warn = 1'($urandom_range(1));
    if (r < 55)      return full_frame(pos, err, warn);
    else if (r < 65) return short_frame(pos, err, warn);
    else if (r < 77) return full_frame(pos, err, warn) ^ (64'd1 << $urandom_range(63));
    else             return noise_frame();
  endfunction

  // --------------------------------------------------------------------------
  // Driving. All tasks but hold_receiver start and end at a falling edge.
  // --------------------------------------------------------------------------

  // offer one word, with random idle cycles first; returns once it is taken
  task automatic send_frame(logic [RAW_W-1:0] frame);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.raw_frame <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_frame <= frame;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // sender stops until every result word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // only called with the decoder empty
  task automatic write_width(logic [PB_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    width_now = clamp_width(value);
    @(negedge clk_i);
  endtask

  // changed at a rising edge so the receiver process reads it race-free
  task automatic set_traffic(int src, int sink);
    @(posedge clk_i);
    src_idle_pct   = src;
    sink_stall_pct = sink;
    @(negedge clk_i);
  endtask

  // long receiver hold-off so the decoder fills and stalls its input
  task automatic hold_receiver(int unsigned cycles);
    @(posedge clk_i);
    rx_block = 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_block = 1'b0;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.raw_frame = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rx_block        = 1'b0;
    src_idle_pct    = 25;
    sink_stall_pct  = 25;
    width_now       = PB_RESET;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, at the reset width of 22
    send_frame('0);                                // empty frame: CRC error
    send_frame('1);
    send_frame(64'd1);                             // start bit only, nothing left
    send_frame(64'd3);                             // start and CDS only
    send_frame(64'h8000_0000_0000_0000);
    send_frame(64'hC000_0000_0000_0000);
    send_frame(full_frame('0, 1'b0, 1'b0));        // first good frame updates held
    send_frame(full_frame('1, 1'b1, 1'b1));        // top bits beyond width ignored
    send_frame(full_frame(POS_W'(22'h3F_FFFF), 1'b0, 1'b1));
    send_frame(full_frame(POS_W'(22'h15_5555), 1'b1, 1'b0));
    send_frame(short_frame(POS_W'(22'h2A_AAAA), 1'b1, 1'b0));
    send_frame(short_frame('0, 1'b0, 1'b1));
    send_frame(short_frame(POS_W'(5), 1'b0, 1'b0) ^ 64'd1);  // bad CRC: held stays
    send_frame(64'hFFFF_FFFF_0000_0000);
    send_frame(64'h0000_0000_FFFF_FFFF);
    send_frame(64'h0000_0000_0000_8001);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_width(WIDTH_PLAN[p]);
      set_traffic(SRC_IDLE[p % 4], SINK_STALL[p % 4]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 20) begin
          fork
            hold_receiver(HOLD_CYCLES);
          join_none
        end
        send_frame(random_item());
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ biss_c_frame_decoder_core.f @@
design/bissc_pkg.sv
design/bissc_in_if.sv
design/bissc_out_if.sv
design/bissc_align.sv
design/bissc_crc6.sv
design/biss_c_frame_decoder_core.sv
bench/bissc_tb_pkg.sv
bench/bissc_frame_checker.sv
bench/tb_top.sv
